// ----- hdl/julian_to_gregorian_date_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef JULIAN_TO_GREGORIAN_DATE_CORE_MACROS_SVH
`define JULIAN_TO_GREGORIAN_DATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JGD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jgd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jgd assertion failed");

`endif

// ----- hdl/jgd_pkg.sv -----
`timescale 1ns / 1ps

package jgd_pkg;

    // Field widths
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Running day count and length operand widths
    localparam int ACC_W = 22;
    localparam int LEN_W = 9;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  FIRST_YEAR  = 14'd1582;
    localparam logic [YEAR_W-1:0]  LAST_YEAR   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_OCT   = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY   = 5'd4;
    localparam logic [DAY_W-1:0]   FEB_DAYS    = 5'd28;
    localparam logic [LEN_W-1:0]   YEAR_DAYS   = 9'd365;

    // Offset between the Julian start ordinal (277) and the Gregorian one (288)
    localparam logic [DAY_W-1:0]   START_SHIFT = 5'd11;

    // Position of 1582 inside the 100-year and 400-year cycles
    localparam logic [6:0] CENT_START = 7'd82;
    localparam logic [6:0] CENT_LAST  = 7'd99;
    localparam logic [8:0] QUAD_START = 9'd382;
    localparam logic [8:0] QUAD_LAST  = 9'd399;

    // Days per month in a common year; codes outside 1..12 read as zero
    localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = MONTH_DAYS[month];
        if (month == MONTH_FEB) begin
            len = FEB_DAYS + {{(DAY_W-1){1'b0}}, leap};
        end
        return len;
    endfunction

    // Request to the shared add/subtract unit
    typedef struct packed {
        logic             sub;
        logic [ACC_W-1:0] a;
        logic [LEN_W-1:0] b;
    } jgd_alu_req_t;

    // Result: sum or difference, and a <= b (valid for subtract)
    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             le;
    } jgd_alu_rsp_t;

endpackage

// ----- hdl/jgd_check.sv -----
`timescale 1ns / 1ps

module jgd_check (
    input  logic [jgd_pkg::YEAR_W-1:0]  year,
    input  logic [jgd_pkg::MONTH_W-1:0] month,
    input  logic [jgd_pkg::DAY_W-1:0]   day,
    output logic                        bad
);
    import jgd_pkg::*;

    logic             year_ok;
    logic             month_ok;
    logic             day_ok;
    logic             too_early;
    logic [DAY_W-1:0] max_day;

    // Reject out-of-range fields, days past month end and dates before the switch
    always_comb begin
        year_ok   = year inside {[FIRST_YEAR:LAST_YEAR]};
        month_ok  = month inside {[MONTH_JAN:MONTH_DEC]};
        max_day   = month_len(month, year[1:0] == 2'b00);
        day_ok    = (day != '0) && (day <= max_day);
        too_early = (year == FIRST_YEAR) &&
                    ((month < MONTH_OCT) || ((month == MONTH_OCT) && (day < FIRST_DAY)));
        bad       = !year_ok || !month_ok || !day_ok || too_early;
    end

endmodule

// ----- hdl/jgd_alu.sv -----
`timescale 1ns / 1ps

module jgd_alu (
    input  jgd_pkg::jgd_alu_req_t req,
    output jgd_pkg::jgd_alu_rsp_t rsp
);
    import jgd_pkg::*;

    logic [ACC_W-1:0] b_ext;
    logic [ACC_W-1:0] b_op;
    logic [ACC_W:0]   sum_full;

    // One adder serves both add and subtract; on subtract, carry out marks a >= b
    always_comb begin
        b_ext    = {{(ACC_W-LEN_W){1'b0}}, req.b};
        b_op     = req.sub ? ~b_ext : b_ext;
        sum_full = {1'b0, req.a} + {1'b0, b_op} + {{ACC_W{1'b0}}, req.sub};
        rsp.res  = sum_full[ACC_W-1:0];
        rsp.le   = !sum_full[ACC_W] || (sum_full[ACC_W-1:0] == '0);
    end

endmodule

// ----- hdl/julian_to_gregorian_date_core.sv -----
`timescale 1ns / 1ps

// Converts one Julian date to the Gregorian calendar, with Julian 1582-10-04
// mapping to Gregorian 1582-10-15. A transaction is taken only while idle;
// the block first sums Julian year and month lengths from 1582 onward, then
// subtracts Gregorian year and month lengths until the remainder fits, one
// year or month per cycle on a single shared adder. The result sits in an
// output register and the next transaction is taken as soon as the result
// has been loaded.
// Rejected dates (out of range, bad month or day, before 1582-10-04) return
// all-zero data with m_tuser set.
module julian_to_gregorian_date_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: julian_year[13:0], julian_month[17:14], julian_day[22:18], zero pad
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jgd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata: greg_year[13:0], greg_month[17:14], greg_day[22:18], zero pad
    // m_tuser: date_invalid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jgd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import jgd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_JYEAR = 6'b000010,
        ST_JMON  = 6'b000100,
        ST_GYEAR = 6'b001000,
        ST_GMON  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [YEAR_W-1:0]    jy_reg, jy_next;
    logic [MONTH_W-1:0]   jm_reg, jm_next;
    logic [YEAR_W-1:0]    y_reg, y_next;
    logic [MONTH_W-1:0]   m_reg, m_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [6:0]           cent_reg, cent_next;
    logic [8:0]           quad_reg, quad_next;
    logic                 bad_reg, bad_next;
    logic                 out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]    out_year_reg, out_year_next;
    logic [MONTH_W-1:0]   out_month_reg, out_month_next;
    logic [DAY_W-1:0]     out_day_reg, out_day_next;
    logic                 out_bad_reg, out_bad_next;

    logic [YEAR_W-1:0]    s_year;
    logic [MONTH_W-1:0]   s_month;
    logic [DAY_W-1:0]     s_day;
    logic                 in_bad;
    logic                 jleap_y;
    logic                 jleap_jy;
    logic                 gleap;
    logic                 load_out;
    logic [LEN_W-1:0]     step_len;
    jgd_alu_req_t         alu_req;
    jgd_alu_rsp_t         alu_rsp;

    // Unpack the input transaction
    assign s_year  = s_tdata[YEAR_W-1:0];
    assign s_month = s_tdata[YEAR_W+MONTH_W-1:YEAR_W];
    assign s_day   = s_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];

    jgd_check u_check (
        .year  (s_year),
        .month (s_month),
        .day   (s_day),
        .bad   (in_bad)
    );

    // Leap rules for the year being walked and for the Julian input year
    assign jleap_y  = (y_reg[1:0] == 2'b00);
    assign jleap_jy = (jy_reg[1:0] == 2'b00);
    assign gleap    = (quad_reg == '0) || (jleap_y && (cent_reg != '0));

    // Pick the length fed to the shared adder
    always_comb begin
        case (state_reg)
            ST_JYEAR: step_len = YEAR_DAYS + {{(LEN_W-1){1'b0}}, jleap_y};
            ST_JMON:  step_len = {{(LEN_W-DAY_W){1'b0}}, month_len(m_reg, jleap_jy)};
            ST_GYEAR: step_len = YEAR_DAYS + {{(LEN_W-1){1'b0}}, gleap};
            ST_GMON:  step_len = {{(LEN_W-DAY_W){1'b0}}, month_len(m_reg, gleap)};
            default:  step_len = '0;
        endcase
    end

    assign alu_req.sub = (state_reg == ST_GYEAR) || (state_reg == ST_GMON);
    assign alu_req.a   = acc_reg;
    assign alu_req.b   = step_len;

    jgd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Sequence the walk: Julian years, Julian months, Gregorian years, Gregorian months
    always_comb begin
        state_next = state_reg;
        jy_next    = jy_reg;
        jm_next    = jm_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        cent_next  = cent_reg;
        quad_next  = quad_reg;
        bad_next   = bad_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    jy_next    = s_year;
                    jm_next    = s_month;
                    y_next     = FIRST_YEAR;
                    m_next     = MONTH_JAN;
                    acc_next   = {{(ACC_W-DAY_W){1'b0}}, s_day}
                               + {{(ACC_W-DAY_W){1'b0}}, START_SHIFT};
                    bad_next   = in_bad;
                    state_next = in_bad ? ST_DONE : ST_JYEAR;
                end
            end
            ST_JYEAR: begin
                if (y_reg == jy_reg) begin
                    state_next = ST_JMON;
                end else begin
                    acc_next = alu_rsp.res;
                    y_next   = y_reg + 1'b1;
                end
            end
            ST_JMON: begin
                if (m_reg == jm_reg) begin
                    y_next     = FIRST_YEAR;
                    cent_next  = CENT_START;
                    quad_next  = QUAD_START;
                    state_next = ST_GYEAR;
                end else begin
                    acc_next = alu_rsp.res;
                    m_next   = m_reg + 1'b1;
                end
            end
            ST_GYEAR: begin
                if (alu_rsp.le) begin
                    m_next     = MONTH_JAN;
                    state_next = ST_GMON;
                end else begin
                    acc_next  = alu_rsp.res;
                    y_next    = y_reg + 1'b1;
                    cent_next = (cent_reg == CENT_LAST) ? '0 : cent_reg + 1'b1;
                    quad_next = (quad_reg == QUAD_LAST) ? '0 : quad_reg + 1'b1;
                end
            end
            ST_GMON: begin
                if (alu_rsp.le || (m_reg >= MONTH_DEC)) begin
                    state_next = ST_DONE;
                end else begin
                    acc_next = alu_rsp.res;
                    m_next   = m_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the output register once the slot is free; drop valid when taken
    always_comb begin
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_bad_next   = bad_reg;
            if (bad_reg) begin
                out_year_next  = '0;
                out_month_next = '0;
                out_day_next   = '0;
            end else begin
                out_year_next  = y_reg;
                out_month_next = m_reg;
                out_day_next   = acc_reg[DAY_W-1:0];
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        jy_reg        <= jy_next;
        jm_reg        <= jm_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        acc_reg       <= acc_next;
        cent_reg      <= cent_next;
        quad_reg      <= quad_next;
        bad_reg       <= bad_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_bad_reg   <= out_bad_next;
    end

    // Pack the result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_bad_reg;
    assign m_tdata  = {{(OUT_TDATA_W-YEAR_W-MONTH_W-DAY_W){1'b0}},
                       out_day_reg, out_month_reg, out_year_reg};

endmodule

// ----- hdl/jgd_checker.sv -----
`timescale 1ns / 1ps

`include "julian_to_gregorian_date_core_macros.svh"

module jgd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jgd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // Hold a stalled result
    `JGD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Go busy after taking an input transaction
    `JGD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Rejected dates carry all-zero data
    `JGD_ASSERT_SAME(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)

    // Accepted dates give a real month, a nonzero day and a year no earlier than the switch
    `JGD_ASSERT_SAME(a_valid_range, aclk, aresetn, m_tvalid && !m_tuser, (m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12) && (m_tdata[13:0] >= 14'd1582) && (m_tdata[22:18] != 5'd0))

endmodule

bind julian_to_gregorian_date_core jgd_checker u_jgd_checker (.*);

// ----- bench/julian_to_gregorian_date_core_tb.sv -----
`timescale 1ns / 1ps

// One converted date as it leaves the block, packed like {m_tuser, m_tdata[22:0]}
typedef struct packed {
    logic                         invalid;
    logic [jgd_pkg::DAY_W-1:0]    day;
    logic [jgd_pkg::MONTH_W-1:0]  month;
    logic [jgd_pkg::YEAR_W-1:0]   year;
} greg_date_t;

// Predicts Gregorian dates for accepted Julian dates and checks the results
class gregorian_date_tracker;
    greg_date_t pending_dates[$];
    int         mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int pending();
        return pending_dates.size();
    endfunction

    static function int unsigned month_days(int unsigned month, bit leap);
        case (month)
            2: begin
                return leap ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            1, 3, 5, 7, 8, 10, 12: begin
                return 31;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    static function bit greg_leap_year(int unsigned year);
        return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
    endfunction

    static function greg_date_t convert_julian_date(int unsigned jy, int unsigned jm,
                                                    int unsigned jd);
        greg_date_t  result;
        int unsigned ordinal;
        int unsigned year;
        int unsigned month;
        int unsigned len;
        bit          rejected;

        result = '0;
        rejected = (jy < jgd_pkg::FIRST_YEAR) || (jy > jgd_pkg::LAST_YEAR) ||
                   (jm < 1) || (jm > 12) ||
                   (jd < 1) || (jd > month_days(jm, jy % 4 == 0)) ||
                   ((jy == jgd_pkg::FIRST_YEAR) && ((jm < 10) || ((jm == 10) && (jd < 4))));
        if (rejected) begin
            result.invalid = 1'b1;
            return result;
        end

        // Julian day count from January 1, 1582
        ordinal = 0;
        for (year = jgd_pkg::FIRST_YEAR; year < jy; year++) begin
            ordinal += (year % 4 == 0) ? 366 : 365;
        end
        for (month = 1; month < jm; month++) begin
            ordinal += month_days(month, jy % 4 == 0);
        end
        ordinal += jd;

        // Shift from the Julian start ordinal to the Gregorian one, then walk forward
        ordinal += jgd_pkg::START_SHIFT;
        year = jgd_pkg::FIRST_YEAR;
        len = greg_leap_year(year) ? 366 : 365;
        while (ordinal > len) begin
            ordinal -= len;
            year++;
            len = greg_leap_year(year) ? 366 : 365;
        end
        month = 1;
        len = month_days(month, greg_leap_year(year));
        while ((ordinal > len) && (month < 12)) begin
            ordinal -= len;
            month++;
            len = month_days(month, greg_leap_year(year));
        end

        result.year  = year[jgd_pkg::YEAR_W-1:0];
        result.month = month[jgd_pkg::MONTH_W-1:0];
        result.day   = ordinal[jgd_pkg::DAY_W-1:0];
        return result;
    endfunction

    function void note_julian_date(int unsigned jy, int unsigned jm, int unsigned jd);
        pending_dates.push_back(convert_julian_date(jy, jm, jd));
    endfunction

    function void check_gregorian_date(greg_date_t got);
        greg_date_t want;

        if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: %0d-%0d-%0d invalid=%0b",
                         got.year, got.month, got.day, got.invalid);
            end
            return;
        end
        want = pending_dates.pop_front();
        if ((got.year !== want.year) || (got.month !== want.month) ||
            (got.day !== want.day) || (got.invalid !== want.invalid)) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected %0d-%0d-%0d invalid=%0b, got %0d-%0d-%0d invalid=%0b",
                         want.year, want.month, want.day, want.invalid,
                         got.year, got.month, got.day, got.invalid);
            end
        end
    endfunction
endclass

module julian_to_gregorian_date_core_tb;
    localparam int RANDOM_ITEMS = 100;
    localparam int STALL_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 50;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [jgd_pkg::IN_TDATA_W-1:0]    s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [jgd_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                              m_tuser;

    logic [7:0]                        ready_pattern = 8'hFF;
    int                                pattern_age = 0;
    int                                idle_cycles = 0;
    gregorian_date_tracker             tracker = new();

    julian_to_gregorian_date_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Rotate the receiver stall pattern, picking a new one now and then
    always @(negedge aclk) begin
        if (pattern_age == 0) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            pattern_age   <= $urandom_range(16, 200);
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
            pattern_age   <= pattern_age - 1;
        end
        m_tready <= ready_pattern[0];
    end

    // Record accepted dates and check returned ones
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            tracker.note_julian_date(32'(s_tdata[13:0]), 32'(s_tdata[17:14]),
                                     32'(s_tdata[22:18]));
        end
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_gregorian_date({m_tuser, m_tdata[22:18], m_tdata[17:14],
                                          m_tdata[13:0]});
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("julian_to_gregorian_date_core_tb NOT OK");
            $finish;
        end
    end

    task automatic send_julian_date(input logic [13:0] jy, input logic [3:0] jm,
                                    input logic [4:0] jd);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, jd, jm, jy};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic hold_sender_idle(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Drop valid and hold until every predicted date has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int          burst;
        int          pick;
        int unsigned len;
        logic [13:0] jy;
        logic [3:0]  jm;
        logic [4:0]  jd;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: start date, range edges, leap days, malformed fields
        send_julian_date(14'd1582, 4'd10, 5'd4);
        send_julian_date(14'd1582, 4'd10, 5'd3);
        send_julian_date(14'd1582, 4'd1, 5'd1);
        send_julian_date(14'd1582, 4'd9, 5'd30);
        send_julian_date(14'd1582, 4'd12, 5'd31);
        send_julian_date(14'd1583, 4'd1, 5'd1);
        send_julian_date(14'd1600, jgd_pkg::MONTH_FEB, 5'd29);
        send_julian_date(14'd1700, jgd_pkg::MONTH_FEB, 5'd29);
        send_julian_date(14'd1701, jgd_pkg::MONTH_FEB, 5'd29);
        send_julian_date(14'd1700, 4'd3, 5'd1);
        send_julian_date(14'd1600, 4'd0, 5'd10);
        send_julian_date(14'd1600, 4'd13, 5'd10);
        send_julian_date(14'd1600, 4'd15, 5'd31);
        send_julian_date(14'd1600, 4'd5, 5'd0);
        send_julian_date(14'd1600, 4'd4, 5'd31);
        send_julian_date(14'd1600, 4'd1, 5'd31);
        send_julian_date(14'd1581, 4'd12, 5'd31);
        send_julian_date(14'd0, 4'd1, 5'd1);
        send_julian_date(14'd10000, 4'd1, 5'd1);
        send_julian_date(14'd16383, 4'd15, 5'd31);
        send_julian_date(14'd9999, 4'd1, 5'd1);
        send_julian_date(14'd9999, 4'd12, 5'd31);
        wait_for_results();

        // Random: mostly well-formed dates in early years, some noise
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 6);
            for (int b = 0; (b < burst) && (n < RANDOM_ITEMS); b++, n++) begin
                if (n == RANDOM_ITEMS / 2) begin
                    wait_for_results();
                end
                if ($urandom_range(0, 99) < 80) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 75) begin
                        jy = 14'(1582 + $urandom_range(0, 60));
                    end else if (pick < 92) begin
                        jy = 14'(1582 + $urandom_range(0, 500));
                    end else begin
                        jy = 14'($urandom_range(1582, 9999));
                    end
                    jm = 4'($urandom_range(1, 12));
                    len = tracker.month_days(32'(jm), jy % 4 == 0);
                    pick = $urandom_range(0, 9);
                    if (pick < 3) begin
                        jd = 5'(len);
                    end else if (pick == 3) begin
                        jd = 5'd1;
                    end else begin
                        jd = 5'($urandom_range(1, len));
                    end
                end else begin
                    if ($urandom_range(0, 1) == 0) begin
                        jy = 14'($urandom_range(0, 16383));
                    end else begin
                        jy = 14'(1582 + $urandom_range(0, 20));
                    end
                    jm = 4'($urandom_range(0, 15));
                    jd = 5'($urandom_range(0, 31));
                end
                send_julian_date(jy, jm, jd);
            end
            if ($urandom_range(0, 3) != 0) begin
                hold_sender_idle($urandom_range(1, 8));
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if ((tracker.mismatches == 0) && (tracker.pending() == 0)) begin
            $display("julian_to_gregorian_date_core_tb OK");
        end else begin
            $display("julian_to_gregorian_date_core_tb NOT OK");
        end
        $finish;
    end
endmodule
